// ----- hdl/assert_macros.svh -----
// Assertion macros used by the decoder sequencer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define PCX_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next.
`define PCX_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pcx_pkg.sv -----
// Types and constants of the planar PCX run-length decoder.
`default_nettype none
package pcx_pkg;

    localparam int unsigned CODE_W  = 8;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned PLANE_W = 2;
    localparam int unsigned RUN_W   = 6;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [CODE_W-1:0]  MARK_BITS  = 8'hC0;
    localparam logic [CODE_W-1:0]  COUNT_BITS = 8'h3F;
    localparam logic [PLANE_W:0]   PLANES     = 3'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BPL    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [POS_W-1:0] CFG_RESET = 16'd1;

    typedef struct packed {
        logic [POS_W-1:0] bytes_per_line;
        logic [POS_W-1:0] image_width;
        logic [POS_W-1:0] image_height;
    } t_cfg;

    typedef struct packed {
        logic [POS_W-1:0]   column;
        logic [PLANE_W-1:0] plane;
        logic [POS_W-1:0]   row;
    } t_pos;

    typedef struct packed {
        t_pos nxt;
        logic visible;
        logic line_end;
        logic pic_end;
    } t_adv;

    typedef struct packed {
        logic [CODE_W-1:0]  pixel_byte;
        logic [POS_W-1:0]   row_index;
        logic [POS_W-1:0]   column_index;
        logic [PLANE_W-1:0] plane_index;
        logic               run_last;
    } t_pix;

endpackage
`default_nettype wire

// ----- hdl/pcx_if.sv -----
// Handshake interfaces for code, pixel and configuration channels.
`default_nettype none
interface pcx_code_if;
    logic                       valid;
    logic                       ready;
    logic [pcx_pkg::CODE_W-1:0] code_byte;
    modport source (output valid, output code_byte, input ready);
    modport sink   (input valid, input code_byte, output ready);
endinterface

interface pcx_pix_if;
    logic                        valid;
    logic                        ready;
    logic [pcx_pkg::CODE_W-1:0]  pixel_byte;
    logic [pcx_pkg::POS_W-1:0]   row_index;
    logic [pcx_pkg::POS_W-1:0]   column_index;
    logic [pcx_pkg::PLANE_W-1:0] plane_index;
    logic                        run_last;
    modport source (output valid, output pixel_byte, output row_index,
                    output column_index, output plane_index, output run_last,
                    input ready);
    modport sink   (input valid, input pixel_byte, input row_index,
                    input column_index, input plane_index, input run_last,
                    output ready);
endinterface

interface pcx_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [pcx_pkg::CFG_IDX_W-1:0] index;
    logic [pcx_pkg::POS_W-1:0]     data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/pcx_planar_rle_decoder.sv -----
// Top level of the planar PCX run-length decoder.
// Channels: i_code takes one compressed byte per request, o_pix gives decoded
// bytes tagged with row, column and plane, i_cfg writes bytes_per_line (0),
// image_width (1) and image_height (2); i_cfg is always ready.
// After a literal is accepted, the sequencer passes through one placement
// state and one flush state before the next request can be taken. A marker
// byte is absorbed without leaving the idle state. A run of n bytes places
// them one after another through the shared position unit, fewer when the
// scanline ends first, then enters the flush state. Each result waits in the
// held register until the next visible placement or the flush state moves it on.
// Results pass through one output register; while the receiver stalls,
// the sequencer holds in its current byte and i_code stays not ready.
// Padding columns give no result but still take a placement step each.
// After the last scanline every request is taken and dropped until reset.
// Reset clears the position, the pending marker and the end-of-picture
// flag, empties the output register and sets all three registers to 1.
`default_nettype none
module pcx_planar_rle_decoder (
    input  wire  i_clk,
    input  wire  i_rst_n,
    pcx_code_if.sink  i_code,
    pcx_pix_if.source o_pix,
    pcx_cfg_if.sink   i_cfg
);
    import pcx_pkg::*;

    t_cfg r_cfg;
    t_pix out;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_per_line <= CFG_RESET;
            r_cfg.image_width    <= CFG_RESET;
            r_cfg.image_height   <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BPL:    r_cfg.bytes_per_line <= i_cfg.data;
                REG_WIDTH:  r_cfg.image_width    <= i_cfg.data;
                REG_HEIGHT: r_cfg.image_height   <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    pcx_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_code.valid),
        .o_in_ready  (i_code.ready),
        .i_code_byte (i_code.code_byte),
        .i_cfg       (r_cfg),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .o_out       (out)
    );

    assign o_pix.pixel_byte   = out.pixel_byte;
    assign o_pix.row_index    = out.row_index;
    assign o_pix.column_index = out.column_index;
    assign o_pix.plane_index  = out.plane_index;
    assign o_pix.run_last     = out.run_last;

endmodule
`default_nettype wire

// ----- hdl/pcx_pos_unit.sv -----
// Shared position advance unit: visibility and column/plane/row wrap.
`default_nettype none
module pcx_pos_unit (
    input  pcx_pkg::t_pos i_pos,
    input  pcx_pkg::t_cfg i_cfg,
    output pcx_pkg::t_adv o_adv
);
    import pcx_pkg::*;

    logic [POS_W:0]   col_inc;
    logic [POS_W:0]   row_inc;
    logic [POS_W:0]   bpl_lim;
    logic [POS_W:0]   hgt_lim;
    logic [PLANE_W:0] plane_inc;
    logic             col_wrap;
    logic             plane_wrap;
    logic             row_wrap;

    // zero in a limit register stands for 65536
    assign bpl_lim   = {i_cfg.bytes_per_line == '0, i_cfg.bytes_per_line};
    assign hgt_lim   = {i_cfg.image_height == '0, i_cfg.image_height};
    assign col_inc   = {1'b0, i_pos.column} + {{POS_W{1'b0}}, 1'b1};
    assign row_inc   = {1'b0, i_pos.row} + {{POS_W{1'b0}}, 1'b1};
    assign plane_inc = {1'b0, i_pos.plane} + {{PLANE_W{1'b0}}, 1'b1};
    assign col_wrap   = col_inc >= bpl_lim;
    assign plane_wrap = plane_inc >= PLANES;
    assign row_wrap   = row_inc >= hgt_lim;

    always_comb begin
        o_adv.visible  = i_pos.column < i_cfg.image_width;
        o_adv.nxt      = i_pos;
        o_adv.line_end = 1'b0;
        o_adv.pic_end  = 1'b0;
        if (col_wrap) begin
            o_adv.nxt.column = '0;
            if (plane_wrap) begin
                o_adv.nxt.plane = '0;
                o_adv.line_end  = 1'b1;
                if (row_wrap) begin
                    o_adv.nxt.row = '0;
                    o_adv.pic_end = 1'b1;
                end else begin
                    o_adv.nxt.row = row_inc[POS_W-1:0];
                end
            end else begin
                o_adv.nxt.plane = plane_inc[PLANE_W-1:0];
            end
        end else begin
            o_adv.nxt.column = col_inc[POS_W-1:0];
        end
    end
endmodule
`default_nettype wire

// ----- hdl/pcx_seq.sv -----
// Decode sequencer: marker parsing, run expansion, held result and output register.
`default_nettype none
`include "assert_macros.svh"
module pcx_seq (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire [pcx_pkg::CODE_W-1:0]    i_code_byte,
    input  pcx_pkg::t_cfg                i_cfg,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output pcx_pkg::t_pix                o_out
);
    import pcx_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_RUN   = 3'b010,
        S_FLUSH = 3'b100
    } t_state;

    t_state            r_state, n_state;
    t_pos              r_pos, n_pos;
    logic [RUN_W-1:0]  r_pend_len, n_pend_len;
    logic              r_run_pend, n_run_pend;
    logic              r_done, n_done;
    logic [RUN_W-1:0]  r_cnt, n_cnt;
    logic [CODE_W-1:0] r_byte, n_byte;
    logic              r_hold_v, n_hold_v;
    t_pix              r_hold, n_hold;
    logic              r_out_v, n_out_v;
    t_pix              r_out, n_out;
    t_adv              adv;
    logic              out_free;
    logic              stall;

    pcx_pos_unit u_pos (
        .i_pos (r_pos),
        .i_cfg (i_cfg),
        .o_adv (adv)
    );

    assign out_free    = !r_out_v || i_out_ready;
    assign stall       = adv.visible && r_hold_v && !out_free;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out       = r_out;

    always_comb begin
        n_state    = r_state;
        n_pos      = r_pos;
        n_pend_len = r_pend_len;
        n_run_pend = r_run_pend;
        n_done     = r_done;
        n_cnt      = r_cnt;
        n_byte     = r_byte;
        n_hold_v   = r_hold_v;
        n_hold     = r_hold;
        n_out_v    = r_out_v;
        n_out      = r_out;
        if (r_out_v && i_out_ready) begin
            n_out_v = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && !r_done) begin
                    if (r_run_pend) begin
                        n_run_pend = 1'b0;
                        n_pend_len = '0;
                        if (r_pend_len != '0) begin
                            n_cnt   = r_pend_len;
                            n_byte  = i_code_byte;
                            n_state = S_RUN;
                        end
                    end else if ((i_code_byte & MARK_BITS) == MARK_BITS) begin
                        n_pend_len = RUN_W'(i_code_byte & COUNT_BITS);
                        n_run_pend = 1'b1;
                    end else begin
                        n_cnt   = RUN_W'(1);
                        n_byte  = i_code_byte;
                        n_state = S_RUN;
                    end
                end
            end
            S_RUN: begin
                if (!stall) begin
                    if (adv.visible) begin
                        if (r_hold_v) begin
                            n_out_v = 1'b1;
                            n_out   = r_hold;
                        end
                        n_hold_v            = 1'b1;
                        n_hold.pixel_byte   = r_byte;
                        n_hold.row_index    = r_pos.row;
                        n_hold.column_index = r_pos.column;
                        n_hold.plane_index  = r_pos.plane;
                        n_hold.run_last     = 1'b0;
                    end
                    n_pos = adv.nxt;
                    if (adv.pic_end) begin
                        n_done = 1'b1;
                    end
                    n_cnt = r_cnt - RUN_W'(1);
                    if (adv.line_end || r_cnt == RUN_W'(1)) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!r_hold_v) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_v        = 1'b1;
                    n_out          = r_hold;
                    n_out.run_last = 1'b1;
                    n_hold_v       = 1'b0;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pos      <= '0;
            r_pend_len <= '0;
            r_run_pend <= 1'b0;
            r_done     <= 1'b0;
            r_cnt      <= '0;
            r_hold_v   <= 1'b0;
            r_out_v    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_pos      <= n_pos;
            r_pend_len <= n_pend_len;
            r_run_pend <= n_run_pend;
            r_done     <= n_done;
            r_cnt      <= n_cnt;
            r_hold_v   <= n_hold_v;
            r_out_v    <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_hold <= n_hold;
        r_out  <= n_out;
    end

    `PCX_ASSERT(a_idle_no_hold, i_clk, i_rst_n, (r_state != S_IDLE) || !r_hold_v, "held result left in idle")
    `PCX_ASSERT(a_run_count, i_clk, i_rst_n, (r_state != S_RUN) || (r_cnt != '0), "run state with zero count")
    `PCX_ASSERT_NEXT(a_done_ignores, i_clk, i_rst_n, r_done && i_in_valid && o_in_ready, r_state == S_IDLE && r_done, "request taken after picture end")
    `PCX_ASSERT_NEXT(a_flush_last, i_clk, i_rst_n, r_state == S_FLUSH && r_hold_v && out_free, r_out_v && r_out.run_last, "flush did not mark last")

endmodule
`default_nettype wire
